### rtl/vpp_pkg.sv
// Package for the particle pool: word types, pool entry type, status codes,
// and the command and status groups between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package vpp_pkg;

	localparam int POOL_DEPTH_DEF = 64;

	// Result status codes
	localparam logic [1:0] ST_ADDED = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_LIVE  = 2'd2;
	localparam logic [1:0] ST_NONE  = 2'd3;

	// Input item actions
	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef struct packed {
		logic               action;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [31:0]        color_rgba;
		logic [31:0]        start_age;
		logic [31:0]        life_span;
		logic [31:0]        delta_time;
	} vpp_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         slot;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [31:0]        out_color;
		logic [6:0]         live_total;
		logic               last;
	} vpp_out_t;

	// One pool slot; dead is the flag left by the aging pass
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic [31:0] color;
		logic [31:0] age;
		logic [31:0] life;
		logic        dead;
	} vpp_part_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // capture input word
		logic add;       // append particle, emit added word
		logic full;      // emit pool-full word
		logic none;      // emit none-live word
		logic u_mul;     // aging/motion products from read data
		logic u_wr;      // write back aged slot
		logic c_ev;      // compaction step on read data
		logic e_out;     // emit live slot from read data
		logic rd_idx;    // read port A at index, port B at last live slot
		logic idx_clr;
		logic idx_inc;
		logic idx_dec;
		logic idx_top;
	} vpp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_tick;
		logic full;
		logic cnt_zero;
		logic idx_end;   // index is the last live slot
		logic idx_zero;
	} vpp_sts_t;

endpackage

### rtl/velocity_particle_pool.sv
// Top level of the particle pool: controller plus datapath.
// Depends on vpp_pkg, vpp_ctrl and vpp_datapath.
`timescale 1ns / 1ps
// A word is taken when start is high and busy is low; results come one per
// strobe and cannot be held off, so the receiver must take each on the cycle
// it shows. An add word yields a single result word. A tick walks the shared
// slot memory once to age and move each live slot (read, multiply, write
// back), once top down to compact, and once to emit survivors, with a read
// step before each word is emitted. A tick leaving no survivors, or finding
// the pool already empty, yields a single none-live word. The last word of
// every item shows in the cycle after busy falls.
module velocity_particle_pool #(
	parameter int POOL_DEPTH = vpp_pkg::POOL_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  vpp_pkg::vpp_in_t item,
	output logic             strobe,
	output vpp_pkg::vpp_out_t result
);
	import vpp_pkg::*;

	vpp_cmd_t cmd;
	vpp_sts_t sts;

	vpp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	vpp_datapath #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result),
		.strobe (strobe)
	);

endmodule

### rtl/vpp_ctrl.sv
// Controller for the particle pool: sequences add, aging, compaction and
// emission passes. Depends on vpp_pkg.
`timescale 1ns / 1ps
module vpp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  vpp_pkg::vpp_sts_t sts,
	output vpp_pkg::vpp_cmd_t cmd,
	output logic              busy
);
	import vpp_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_DISP  = 13'b0000000000010,
		S_ADD   = 13'b0000000000100,
		S_FULL  = 13'b0000000001000,
		S_NONE  = 13'b0000000010000,
		S_U_RD  = 13'b0000000100000,
		S_U_MUL = 13'b0000001000000,
		S_U_WR  = 13'b0000010000000,
		S_C_RD  = 13'b0000100000000,
		S_C_EV  = 13'b0001000000000,
		S_CHK   = 13'b0010000000000,
		S_E_RD  = 13'b0100000000000,
		S_E_OUT = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (!sts.is_tick) begin
					state_d = sts.full ? S_FULL : S_ADD;
				end else if (sts.cnt_zero) begin
					state_d = S_NONE;
				end else begin
					cmd.idx_clr = 1'b1;
					state_d     = S_U_RD;
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_IDLE;
			end
			S_FULL: begin
				cmd.full = 1'b1;
				state_d  = S_IDLE;
			end
			S_NONE: begin
				cmd.none = 1'b1;
				state_d  = S_IDLE;
			end
			S_U_RD: begin
				cmd.rd_idx = 1'b1;
				state_d    = S_U_MUL;
			end
			S_U_MUL: begin
				cmd.u_mul = 1'b1;
				state_d   = S_U_WR;
			end
			S_U_WR: begin
				cmd.u_wr = 1'b1;
				if (sts.idx_end) begin
					cmd.idx_top = 1'b1;
					state_d     = S_C_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_U_RD;
				end
			end
			S_C_RD: begin
				cmd.rd_idx = 1'b1;
				state_d    = S_C_EV;
			end
			S_C_EV: begin
				cmd.c_ev = 1'b1;
				if (sts.idx_zero) begin
					state_d = S_CHK;
				end else begin
					cmd.idx_dec = 1'b1;
					state_d     = S_C_RD;
				end
			end
			S_CHK: begin
				if (sts.cnt_zero) begin
					state_d = S_NONE;
				end else begin
					cmd.idx_clr = 1'b1;
					state_d     = S_E_RD;
				end
			end
			S_E_RD: begin
				cmd.rd_idx = 1'b1;
				state_d    = S_E_OUT;
			end
			S_E_OUT: begin
				cmd.e_out = 1'b1;
				if (sts.idx_end) begin
					state_d = S_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_E_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

### rtl/vpp_datapath.sv
// Datapath for the particle pool: slot memory, index and live counters,
// aging/motion arithmetic and result register. Depends on vpp_pkg.
`timescale 1ns / 1ps
module vpp_datapath #(
	parameter int POOL_DEPTH = vpp_pkg::POOL_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vpp_pkg::vpp_in_t  item,
	input  vpp_pkg::vpp_cmd_t cmd,
	output vpp_pkg::vpp_sts_t sts,
	output vpp_pkg::vpp_out_t result,
	output logic              strobe
);
	import vpp_pkg::*;

	localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int CW = $clog2(POOL_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

	vpp_part_t mem [POOL_DEPTH];
	vpp_part_t rd_a_q, rd_b_q;
	vpp_in_t   in_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] top_c;
	logic [AW-1:0] top_a;
	logic [31:0]   idx_w, cnt_w, cnt_inc_w;

	// Aging stage registers
	vpp_part_t          ent_s1;
	logic [31:0]        age_s1;
	logic               dead_s1;
	logic signed [64:0] px_s1, py_s1, pz_s1;

	logic [32:0]   age_sum;
	logic signed [32:0] dt_s;
	vpp_part_t     upd;
	vpp_part_t     wdat;
	logic [AW-1:0] waddr;
	logic          we;
	vpp_out_t      res_d;
	logic          res_v;

	function automatic logic [31:0] advance(input logic [31:0] pos,
		input logic signed [64:0] prod);
		logic signed [48:0] step;
		logic signed [49:0] sum;
		begin
			// arithmetic shift floors toward minus infinity
			step = prod[64:16];
			sum  = 50'(signed'(pos)) + 50'(step);
			if (sum > 50'sd2147483647) begin
				advance = 32'h7FFF_FFFF;
			end else if (sum < -50'sd2147483648) begin
				advance = 32'h8000_0000;
			end else begin
				advance = sum[31:0];
			end
		end
	endfunction

	assign top_c     = cnt_q - CW'(1);
	assign top_a     = top_c[AW-1:0];
	assign idx_w     = 32'(idx_q);
	assign cnt_w     = 32'(cnt_q);
	assign cnt_inc_w = 32'(cnt_q + CW'(1));

	// Status to controller
	assign sts.is_tick  = (in_q.action == ACT_TICK);
	assign sts.full     = (cnt_q >= DEPTH_C);
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.idx_end  = (CW'(idx_q) == top_c);
	assign sts.idx_zero = (idx_q == '0);

	// Input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= item;
		end
	end

	// Memory reads: port A at index, port B at last live slot
	always_ff @(posedge clk) begin
		if (cmd.rd_idx) begin
			rd_a_q <= mem[idx_q];
			rd_b_q <= mem[top_a];
		end
	end

	// Aging and motion products
	assign age_sum = {1'b0, rd_a_q.age} + {1'b0, in_q.delta_time};
	assign dt_s    = signed'({1'b0, in_q.delta_time});

	always_ff @(posedge clk) begin
		if (cmd.u_mul) begin
			ent_s1  <= rd_a_q;
			age_s1  <= age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
			dead_s1 <= (age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0]) > rd_a_q.life;
			px_s1   <= 65'(signed'(rd_a_q.vx)) * 65'(dt_s);
			py_s1   <= 65'(signed'(rd_a_q.vy)) * 65'(dt_s);
			pz_s1   <= 65'(signed'(rd_a_q.vz)) * 65'(dt_s);
		end
	end

	// Write-back word of an aged slot
	always_comb begin
		upd      = ent_s1;
		upd.age  = age_s1;
		upd.dead = dead_s1;
		if (!dead_s1) begin
			upd.x = advance(ent_s1.x, px_s1);
			upd.y = advance(ent_s1.y, py_s1);
			upd.z = advance(ent_s1.z, pz_s1);
		end
	end

	// Memory write select
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdat  = upd;
		if (cmd.add) begin
			we    = 1'b1;
			waddr = cnt_q[AW-1:0];
			wdat  = '{x: in_q.pos_x, y: in_q.pos_y, z: in_q.pos_z,
				vx: in_q.vel_x, vy: in_q.vel_y, vz: in_q.vel_z,
				color: in_q.color_rgba, age: in_q.start_age,
				life: in_q.life_span, dead: 1'b0};
		end else if (cmd.u_wr) begin
			we = 1'b1;
		end else if (cmd.c_ev) begin
			// dead slot takes the current last particle
			we   = rd_a_q.dead && (CW'(idx_q) != top_c);
			wdat = rd_b_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdat;
		end
	end

	// Index and live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.add) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.c_ev && rd_a_q.dead) begin
				cnt_q <= top_c;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_top) begin
				idx_q <= top_a;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - AW'(1);
			end
		end
	end

	// Result word
	always_comb begin
		res_d = '0;
		res_v = 1'b1;
		if (cmd.add) begin
			res_d.status     = ST_ADDED;
			res_d.slot       = cnt_w[5:0];
			res_d.out_x      = in_q.pos_x;
			res_d.out_y      = in_q.pos_y;
			res_d.out_z      = in_q.pos_z;
			res_d.out_color  = in_q.color_rgba;
			res_d.live_total = cnt_inc_w[6:0];
			res_d.last       = 1'b1;
		end else if (cmd.full) begin
			res_d.status     = ST_FULL;
			res_d.live_total = cnt_w[6:0];
			res_d.last       = 1'b1;
		end else if (cmd.none) begin
			res_d.status = ST_NONE;
			res_d.last   = 1'b1;
		end else if (cmd.e_out) begin
			res_d.status     = ST_LIVE;
			res_d.slot       = idx_w[5:0];
			res_d.out_x      = rd_a_q.x;
			res_d.out_y      = rd_a_q.y;
			res_d.out_z      = rd_a_q.z;
			res_d.out_color  = rd_a_q.color;
			res_d.live_total = cnt_w[6:0];
			res_d.last       = sts.idx_end;
		end else begin
			res_v = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_v) begin
			result <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= res_v;
		end
	end

endmodule

### rtl/vpp_checker.sv
// Port-level checks for the particle pool, bound to the top level.
// Depends on vpp_pkg and velocity_particle_pool.
`timescale 1ns / 1ps
module vpp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              strobe,
	input vpp_pkg::vpp_out_t result
);
	import vpp_pkg::*;

	// an accepted word always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// add and full answers are single words
	a_add_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.status == ST_ADDED || result.status == ST_FULL)
		|-> result.last)
		else $error("add result without last");

	// none-live word carries zero count
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status == ST_NONE |-> result.last && result.live_total == 7'd0)
		else $error("bad none-live word");

	// more words follow a non-final one, so block stays busy
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> busy && !strobe)
		else $error("emission gap broken");

endmodule

bind velocity_particle_pool vpp_checker u_vpp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.result (result)
);
